FILE: sv/crystal_grain_face_query_top_macros.svh
// Assertion macros shared by the checker of the crystal grain face query block.
`ifndef CRYSTAL_GRAIN_FACE_QUERY_TOP_MACROS_SVH
`define CRYSTAL_GRAIN_FACE_QUERY_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGFQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CGFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cgfq_pkg.sv
// Types and constants of the crystal grain face query block.
package cgfq_pkg;

    localparam int PERIOD      = 256;
    localparam int PERIOD_W    = 8;
    localparam int CRD_W       = PERIOD_W + 1;
    localparam int HALF        = PERIOD / 2;
    localparam int WRAP_OFFSET = (255 * PERIOD / 2) % PERIOD;

    localparam int DOT_W = 32;
    localparam int NUM_W = 50;
    localparam int DEN_W = 40;
    localparam int QUO_W = 34;

    localparam logic signed [31:0] REL_START = 32'(PERIOD * 65536);
    localparam logic signed [31:0] REL_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] REL_MIN   = 32'sh8000_0000;
    localparam logic signed [NUM_W-1:0] ABS_START = NUM_W'(PERIOD) <<< 28;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_GROW   = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    localparam logic [1:0] CFG_GRAIN_X = 2'd0;
    localparam logic [1:0] CFG_GRAIN_Y = 2'd1;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
        logic [15:0]        growth_speed;
        logic [23:0]        grow_amount;
        logic [11:0]        point_x;
        logic [11:0]        point_y;
        logic [11:0]        point_z;
    } in_t;

    typedef struct packed {
        logic               is_inside;
        logic [3:0]         closest_plane;
        logic signed [31:0] rel_distance;
        logic               rel_valid;
    } out_t;

    typedef struct packed {
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
        logic [15:0]        speed;
        logic [31:0]        flux;
        logic [23:0]        last_growth;
        logic [47:0]        level;
    } plane_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_G_RD,
        ST_G_ADD,
        ST_G_MUL,
        ST_Q_RD,
        ST_Q_M0,
        ST_Q_M1,
        ST_Q_M2,
        ST_Q_M3,
        ST_Q_M4,
        ST_Q_EVAL,
        ST_Q_SET,
        ST_Q_DIV,
        ST_Q_FIN,
        ST_DONE
    } state_t;

endpackage

FILE: sv/crystal_grain_face_query_top.sv
// Crystal grain face table: append, grow and point query over a plane memory.
// Append writes from idle; grow takes each plane through read, add and multiply-write steps.
// Query takes each plane through read, multiply, evaluate, set-up, the 34-step divider and
// finish; a zero divisor ends a plane at evaluate, a quotient overflow skips the divider.
// An empty table answers from idle through done. One word is worked on at a time.
// rst_n (asynchronous, active low) empties the table and clears the grain centre;
// the plane memory itself is not cleared.
module crystal_grain_face_query_top #(
    parameter int MAX_PLANES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cgfq_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cgfq_pkg::out_t   out_data,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [11:0]      cfg_wdata
);

    localparam int IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CNT_W = $clog2(MAX_PLANES + 1);

    // Plane memory: one write port, one registered read port addressed by the walk index.
    cgfq_pkg::plane_t plane_mem [MAX_PLANES];
    cgfq_pkg::plane_t rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    cgfq_pkg::plane_t wr_data;

    // Control and datapath registers.
    cgfq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [11:0]      grain_x_reg, grain_y_reg;
    logic [23:0]      amt_reg, amt_next;
    logic [31:0]      nf_reg, nf_next;
    logic signed [cgfq_pkg::CRD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [11:0]      z_reg, z_next;
    logic signed [cgfq_pkg::DOT_W-1:0] acc_reg, acc_next;
    logic [47:0]      prod_reg, prod_next;
    logic [cgfq_pkg::DEN_W-1:0] den_reg, den_next;
    logic signed [cgfq_pkg::NUM_W-1:0] num_reg, num_next;
    logic [cgfq_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [cgfq_pkg::QUO_W-1:0] sh_reg, sh_next, quo_reg, quo_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             neg_reg, neg_next, ovf_reg, ovf_next;
    logic             inside_reg, inside_next, ok_reg, ok_next;
    logic [IDX_W-1:0] face_reg, face_next;
    logic signed [cgfq_pkg::NUM_W-1:0] best_abs_reg, best_abs_next;
    logic signed [31:0] best_rel_reg, best_rel_next;
    logic             out_valid_reg, out_valid_next;
    cgfq_pkg::out_t   out_data_reg, out_data_next;

    // Shared multiplier, operands chosen by the sequencer state.
    logic signed [16:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [49:0] mul_p;

    // Combinational temporaries.
    logic [12:0]      wx_sum, wy_sum;
    logic [32:0]      flux_sum;
    logic signed [cgfq_pkg::NUM_W-1:0] dq, lvl, ad, mag;
    logic [40:0]      trial;
    logic             trial_ge;
    logic [34:0]      mag_q;
    logic signed [31:0] rel_cand;
    logic [CNT_W-1:0] idx_plus1;
    logic             last_plane;

    assign in_ready  = (state_reg == cgfq_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign idx_plus1  = CNT_W'(idx_reg) + CNT_W'(1);
    assign last_plane = (idx_plus1 == count_reg);
    assign mul_p      = mul_a * mul_b;

    always_comb
    begin
        mul_a = 17'($signed(rd_data_reg.coef_a));
        mul_b = 33'(x_reg);
        case (state_reg)
            cgfq_pkg::ST_Q_M1:
            begin
                mul_a = 17'($signed(rd_data_reg.coef_b));
                mul_b = 33'(y_reg);
            end
            cgfq_pkg::ST_Q_M2:
            begin
                mul_a = 17'($signed(rd_data_reg.coef_c));
                mul_b = $signed({21'd0, z_reg});
            end
            cgfq_pkg::ST_Q_M3:
            begin
                mul_a = $signed({1'b0, rd_data_reg.speed});
                mul_b = $signed({1'b0, rd_data_reg.flux - 32'(rd_data_reg.last_growth)});
            end
            cgfq_pkg::ST_Q_M4:
            begin
                mul_a = $signed({1'b0, rd_data_reg.speed});
                mul_b = $signed({9'd0, rd_data_reg.last_growth});
            end
            cgfq_pkg::ST_G_MUL:
            begin
                mul_a = $signed({1'b0, rd_data_reg.speed});
                mul_b = $signed({1'b0, nf_reg});
            end
            default:
            begin
                mul_a = 17'($signed(rd_data_reg.coef_a));
                mul_b = 33'(x_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            plane_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= plane_mem[idx_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        amt_next       = amt_reg;
        nf_next        = nf_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        ovf_next       = ovf_reg;
        inside_next    = inside_reg;
        ok_next        = ok_reg;
        face_next      = face_reg;
        best_abs_next  = best_abs_reg;
        best_rel_next  = best_rel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data_reg;

        wx_sum = 13'({1'b0, in_data.point_x}) - 13'({1'b0, grain_x_reg})
               + 13'(cgfq_pkg::WRAP_OFFSET);
        wy_sum = 13'({1'b0, in_data.point_y}) - 13'({1'b0, grain_y_reg})
               + 13'(cgfq_pkg::WRAP_OFFSET);
        flux_sum = {1'b0, rd_data_reg.flux} + 33'(amt_reg);
        dq  = $signed({{4{acc_reg[cgfq_pkg::DOT_W-1]}}, acc_reg, 14'd0});
        lvl = $signed({2'b00, rd_data_reg.level});
        ad  = lvl - dq;
        mag = num_reg[cgfq_pkg::NUM_W-1] ? -num_reg : num_reg;
        trial    = {rem_reg, sh_reg[cgfq_pkg::QUO_W-1]};
        trial_ge = (trial >= {1'b0, den_reg});
        mag_q    = {1'b0, quo_reg} + 35'(rem_reg != '0);
        if (neg_reg)
        begin
            rel_cand = (ovf_reg || mag_q > 35'h0_8000_0000) ? cgfq_pkg::REL_MIN
                     : $signed(32'(35'd0 - mag_q));
        end
        else
        begin
            rel_cand = (ovf_reg || quo_reg > 34'h0_7FFF_FFFF) ? cgfq_pkg::REL_MAX
                     : $signed(quo_reg[31:0]);
        end

        case (state_reg)
            cgfq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.command)
                        cgfq_pkg::CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_PLANES))
                            begin
                                wr_en               = 1'b1;
                                wr_addr             = IDX_W'(count_reg);
                                wr_data.coef_a      = in_data.coef_a;
                                wr_data.coef_b      = in_data.coef_b;
                                wr_data.coef_c      = in_data.coef_c;
                                wr_data.speed       = in_data.growth_speed;
                                wr_data.flux        = '0;
                                wr_data.last_growth = '0;
                                wr_data.level       = '0;
                                count_next          = count_reg + CNT_W'(1);
                            end
                        end
                        cgfq_pkg::CMD_GROW:
                        begin
                            amt_next = in_data.grow_amount;
                            idx_next = '0;
                            if (count_reg != '0)
                            begin
                                state_next = cgfq_pkg::ST_G_RD;
                            end
                        end
                        cgfq_pkg::CMD_QUERY:
                        begin
                            x_next        = $signed({1'b0, wx_sum[cgfq_pkg::PERIOD_W-1:0]})
                                          - $signed(cgfq_pkg::CRD_W'(cgfq_pkg::HALF));
                            y_next        = $signed({1'b0, wy_sum[cgfq_pkg::PERIOD_W-1:0]})
                                          - $signed(cgfq_pkg::CRD_W'(cgfq_pkg::HALF));
                            z_next        = in_data.point_z;
                            idx_next      = '0;
                            inside_next   = 1'b1;
                            ok_next       = 1'b1;
                            face_next     = '0;
                            best_abs_next = cgfq_pkg::ABS_START;
                            best_rel_next = cgfq_pkg::REL_START;
                            state_next    = (count_reg == '0) ? cgfq_pkg::ST_DONE
                                                              : cgfq_pkg::ST_Q_RD;
                        end
                        default:
                        begin
                            state_next = cgfq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            cgfq_pkg::ST_G_RD:
            begin
                state_next = cgfq_pkg::ST_G_ADD;
            end
            cgfq_pkg::ST_G_ADD:
            begin
                nf_next    = flux_sum[32] ? 32'hFFFF_FFFF : flux_sum[31:0];
                state_next = cgfq_pkg::ST_G_MUL;
            end
            cgfq_pkg::ST_G_MUL:
            begin
                wr_en               = 1'b1;
                wr_data.flux        = nf_reg;
                wr_data.last_growth = amt_reg;
                wr_data.level       = mul_p[47:0];
                if (last_plane)
                begin
                    state_next = cgfq_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = cgfq_pkg::ST_G_RD;
                end
            end
            cgfq_pkg::ST_Q_RD:
            begin
                state_next = cgfq_pkg::ST_Q_M0;
            end
            cgfq_pkg::ST_Q_M0:
            begin
                acc_next   = mul_p[cgfq_pkg::DOT_W-1:0];
                state_next = cgfq_pkg::ST_Q_M1;
            end
            cgfq_pkg::ST_Q_M1:
            begin
                acc_next   = acc_reg + mul_p[cgfq_pkg::DOT_W-1:0];
                state_next = cgfq_pkg::ST_Q_M2;
            end
            cgfq_pkg::ST_Q_M2:
            begin
                acc_next   = acc_reg + mul_p[cgfq_pkg::DOT_W-1:0];
                state_next = cgfq_pkg::ST_Q_M3;
            end
            cgfq_pkg::ST_Q_M3:
            begin
                prod_next  = mul_p[47:0];
                state_next = cgfq_pkg::ST_Q_M4;
            end
            cgfq_pkg::ST_Q_M4:
            begin
                den_next   = mul_p[cgfq_pkg::DEN_W-1:0];
                state_next = cgfq_pkg::ST_Q_EVAL;
            end
            cgfq_pkg::ST_Q_EVAL:
            begin
                // Inside test and absolute distance use the level stored at grow time.
                if (!(dq < lvl))
                begin
                    inside_next = 1'b0;
                end
                if (ad < best_abs_reg)
                begin
                    best_abs_next = ad;
                    face_next     = idx_reg;
                end
                num_next = dq - $signed({2'b00, prod_reg});
                if (rd_data_reg.speed == '0 || rd_data_reg.last_growth == '0)
                begin
                    // A zero divisor saturates high, which never beats the start value.
                    ok_next = 1'b0;
                    if (last_plane)
                    begin
                        state_next = cgfq_pkg::ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = cgfq_pkg::ST_Q_RD;
                    end
                end
                else
                begin
                    state_next = cgfq_pkg::ST_Q_SET;
                end
            end
            cgfq_pkg::ST_Q_SET:
            begin
                neg_next = num_reg[cgfq_pkg::NUM_W-1];
                rem_next = cgfq_pkg::DEN_W'(mag[48:18]);
                ovf_next = (cgfq_pkg::DEN_W'(mag[48:18]) >= den_reg);
                sh_next  = {mag[17:0], 16'd0};
                quo_next = '0;
                cnt_next = '0;
                state_next = (cgfq_pkg::DEN_W'(mag[48:18]) >= den_reg) ? cgfq_pkg::ST_Q_FIN
                                                                       : cgfq_pkg::ST_Q_DIV;
            end
            cgfq_pkg::ST_Q_DIV:
            begin
                rem_next = trial_ge ? cgfq_pkg::DEN_W'(trial - {1'b0, den_reg})
                                    : trial[cgfq_pkg::DEN_W-1:0];
                quo_next = {quo_reg[cgfq_pkg::QUO_W-2:0], trial_ge};
                sh_next  = {sh_reg[cgfq_pkg::QUO_W-2:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(cgfq_pkg::QUO_W - 1))
                begin
                    state_next = cgfq_pkg::ST_Q_FIN;
                end
            end
            cgfq_pkg::ST_Q_FIN:
            begin
                if (rel_cand < best_rel_reg)
                begin
                    best_rel_next = rel_cand;
                end
                if (last_plane)
                begin
                    state_next = cgfq_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = cgfq_pkg::ST_Q_RD;
                end
            end
            cgfq_pkg::ST_DONE:
            begin
                // The result waits here only while the output register still holds a word.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.is_inside     = inside_reg;
                    out_data_next.closest_plane = 4'(face_reg);
                    out_data_next.rel_distance  = best_rel_reg;
                    out_data_next.rel_valid     = ok_reg;
                    state_next                  = cgfq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cgfq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cgfq_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            grain_x_reg   <= '0;
            grain_y_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en && cfg_index == cgfq_pkg::CFG_GRAIN_X)
            begin
                grain_x_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == cgfq_pkg::CFG_GRAIN_Y)
            begin
                grain_y_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg      <= amt_next;
        nf_reg       <= nf_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        sh_reg       <= sh_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        ovf_reg      <= ovf_next;
        inside_reg   <= inside_next;
        ok_reg       <= ok_next;
        face_reg     <= face_next;
        best_abs_reg <= best_abs_next;
        best_rel_reg <= best_rel_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: sv/cgfq_checker.sv
// Port-level checker of the crystal grain face query block and its bind.
`include "crystal_grain_face_query_top_macros.svh"

module cgfq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input cgfq_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input cgfq_pkg::out_t out_data
);

    `CGFQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result word changed")
    `CGFQ_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_data.command == cgfq_pkg::CMD_QUERY, !in_ready, "query did not occupy the block")
    `CGFQ_ASSERT_NEXT(a_append_quick, in_valid && in_ready && in_data.command == cgfq_pkg::CMD_APPEND, in_ready, "append took more than one cycle")
    `CGFQ_ASSERT_SAME(a_rel_cap, out_valid, out_data.rel_distance <= cgfq_pkg::REL_START, "relative distance above its start value")

endmodule

bind crystal_grain_face_query_top cgfq_checker u_cgfq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: test/tb_crystal_grain_face_query_top.sv
// Self-checking testbench for the crystal grain face query block.
module tb_crystal_grain_face_query_top;

    localparam int NPLANES = 16;
    localparam int PER     = 256;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    cgfq_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    cgfq_pkg::out_t out_data;
    logic           cfg_wr_en;
    logic [1:0]     cfg_index;
    logic [11:0]    cfg_wdata;

    crystal_grain_face_query_top #(.MAX_PLANES(NPLANES)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // Shadow copy of the plane table and the grain centre.
    logic signed [15:0] sh_a [NPLANES];
    logic signed [15:0] sh_b [NPLANES];
    logic signed [15:0] sh_c [NPLANES];
    logic [15:0]        sh_speed [NPLANES];
    logic [31:0]        sh_flux [NPLANES];
    logic [31:0]        sh_growth [NPLANES];
    logic [63:0]        sh_level [NPLANES];
    int                 sh_count;
    logic [11:0]        centre_x;
    logic [11:0]        centre_y;

    cgfq_pkg::in_t  pending_words [$];
    cgfq_pkg::out_t answers_due [$];
    int   mismatches;
    int   errors;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Fold one lattice coordinate around the grain centre.
    function automatic longint fold_coord(logic [11:0] p, logic [11:0] c);
        longint s;
        longint m;
        begin
            s = longint'(p) - longint'(c) + longint'(255 * PER / 2);
            m = s % PER;
            if (m < 0)
                m += PER;
            return m - PER / 2;
        end
    endfunction

    // Relative growth distance of one plane; clears ok on a zero divisor.
    function automatic logic signed [31:0] rel_growth(int i, longint dot, inout bit ok);
        longint d, df, f, den, num, q, r, v;
        begin
            d  = longint'(sh_speed[i]);
            df = longint'(sh_growth[i]);
            f  = longint'(sh_flux[i]);
            if (d == 0 || df == 0)
            begin
                ok = 1'b0;
                return 32'sh7FFF_FFFF;
            end
            den = d * df;
            num = dot * 16384 - (f - df) * d;
            q = num / den;
            if ((num % den) != 0 && num < 0)
                q--;
            r = num - q * den;
            if (q >= 32768)
                return 32'sh7FFF_FFFF;
            if (q < -32768)
                return 32'sh8000_0000;
            v = q * 65536 + (r * 65536) / den;
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return v[31:0];
        end
    endfunction

    // Applies one accepted word to the shadow table and queues any answer.
    task automatic apply_word(cgfq_pkg::in_t w);
        longint x, y, z, dot, dq, ad, best_abs, lvl, nf;
        logic signed [31:0] rd, best_rel;
        bit below_all, ok;
        int face;
        cgfq_pkg::out_t o;
        begin
            case (cgfq_pkg::cmd_t'(w.command))
                cgfq_pkg::CMD_APPEND:
                    if (sh_count < NPLANES)
                    begin
                        sh_a[sh_count] = w.coef_a;
                        sh_b[sh_count] = w.coef_b;
                        sh_c[sh_count] = w.coef_c;
                        sh_speed[sh_count] = w.growth_speed;
                        sh_flux[sh_count] = '0;
                        sh_growth[sh_count] = '0;
                        sh_level[sh_count] = '0;
                        sh_count++;
                    end
                cgfq_pkg::CMD_GROW:
                    for (int i = 0; i < sh_count; i++)
                    begin
                        nf = longint'(sh_flux[i]) + longint'(w.grow_amount);
                        if (nf > 64'hFFFF_FFFF)
                            nf = 64'hFFFF_FFFF;
                        sh_flux[i] = nf[31:0];
                        sh_growth[i] = 32'(w.grow_amount);
                        sh_level[i] = 64'(sh_speed[i]) * 64'(nf);
                    end
                cgfq_pkg::CMD_QUERY:
                begin
                    x = fold_coord(w.point_x, centre_x);
                    y = fold_coord(w.point_y, centre_y);
                    z = longint'(w.point_z);
                    below_all = 1'b1;
                    ok = 1'b1;
                    best_abs = longint'(PER) <<< 28;
                    best_rel = 32'(PER * 65536);
                    face = 0;
                    for (int i = 0; i < sh_count; i++)
                    begin
                        dot = longint'(sh_a[i]) * x + longint'(sh_b[i]) * y
                            + longint'(sh_c[i]) * z;
                        lvl = longint'(sh_level[i]);
                        dq = dot * 16384;
                        ad = lvl - dq;
                        rd = rel_growth(i, dot, ok);
                        if (!(dq < lvl))
                            below_all = 1'b0;
                        if (rd < best_rel)
                            best_rel = rd;
                        if (ad < best_abs)
                        begin
                            best_abs = ad;
                            face = i;
                        end
                    end
                    o.is_inside = below_all;
                    o.closest_plane = face[3:0];
                    o.rel_distance = best_rel;
                    o.rel_valid = ok;
                    answers_due = {answers_due, o};
                end
                default: ;
            endcase
        end
    endtask

    // Driver: bursts of words with random gaps. Valid stays high across a burst.
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            // A word is taken at this edge if valid and ready were both high.
            if (in_valid && in_ready)
            begin
                apply_word(in_data);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_data <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready follows a slowly changing stall pattern.
    int stall_mode;
    int stall_count;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode <= 0;
            stall_count <= 0;
        end
        else
        begin
            if (stall_count == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_count <= $urandom_range(5, 60);
            end
            else
                stall_count <= stall_count - 1;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: each accepted answer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected answer %p", out_data);
                mismatches++;
            end
            else if (out_data !== answers_due[0])
            begin
                errors++;
                if (mismatches < 10)
                    $display("mismatch: expected %p, got %p", answers_due[0], out_data);
                mismatches++;
                void'(answers_due.pop_front());
            end
            else
                void'(answers_due.pop_front());
        end
    end

    function automatic cgfq_pkg::in_t rand_word(cgfq_pkg::cmd_t c);
        cgfq_pkg::in_t w;
        begin
            w.command = c;
            w.coef_a = 16'($urandom);
            w.coef_b = 16'($urandom);
            w.coef_c = 16'($urandom);
            w.growth_speed = 16'($urandom);
            w.grow_amount = 24'($urandom);
            w.point_x = 12'($urandom);
            w.point_y = 12'($urandom);
            w.point_z = 12'($urandom);
            // Small values now and then, so that plenty of answers fall in range.
            if ($urandom_range(0, 2) == 0)
            begin
                w.coef_a = $signed(16'($urandom_range(0, 2048))) - 16'sd1024;
                w.growth_speed = 16'($urandom_range(0, 8));
                w.grow_amount = 24'($urandom_range(0, 512));
                w.point_z = 12'($urandom_range(0, 16));
            end
            return w;
        end
    endfunction

    // Waits until every word has gone in and every answer has come out,
    // then lets a full-table query time pass before the block is touched.
    task automatic drain();
        begin
            while (pending_words.size() > 0 || in_valid)
                @(posedge clk);
            while (answers_due.size() > 0)
                @(posedge clk);
            repeat (NPLANES * 43 + 20) @(posedge clk);
        end
    endtask

    task automatic write_centre(logic [11:0] gx, logic [11:0] gy);
        begin
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= cgfq_pkg::CFG_GRAIN_X;
            cfg_wdata <= gx;
            @(posedge clk);
            cfg_index <= cgfq_pkg::CFG_GRAIN_Y;
            cfg_wdata <= gy;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            centre_x = gx;
            centre_y = gy;
        end
    endtask

    task automatic add_word(cgfq_pkg::in_t w);
        pending_words = {pending_words, w};
    endtask

    task automatic add_cmd(cgfq_pkg::cmd_t c);
        add_word(rand_word(c));
    endtask

    initial
    begin
        cgfq_pkg::in_t w;
        logic [11:0] cx [4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = cgfq_pkg::CFG_GRAIN_X;
        cfg_wdata = '0;
        sh_count = 0;
        centre_x = '0;
        centre_y = '0;
        mismatches = 0;
        errors = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-table query, extremes, zero divisors, full table.
        w = '0;
        w.command = cgfq_pkg::CMD_QUERY;
        add_word(w);
        w.command = cgfq_pkg::CMD_NOP;
        w.point_x = 12'hFFF;
        add_word(w);
        w = '0;
        w.command = cgfq_pkg::CMD_APPEND;
        w.coef_a = 16'sh7FFF;
        w.coef_b = 16'sh8000;
        w.coef_c = 16'sh7FFF;
        w.growth_speed = 16'hFFFF;
        add_word(w);
        w.coef_a = 16'sh8000;
        w.coef_b = 16'sh7FFF;
        w.coef_c = 16'sh8000;
        w.growth_speed = 16'h0000;
        add_word(w);
        w = '0;
        w.command = cgfq_pkg::CMD_QUERY;
        w.point_x = 12'hFFF;
        w.point_y = 12'h000;
        w.point_z = 12'hFFF;
        add_word(w);
        w = '0;
        w.command = cgfq_pkg::CMD_GROW;
        w.grow_amount = 24'hFFFFFF;
        for (int k = 0; k < 300; k++)
            add_word(w);
        w = '0;
        w.command = cgfq_pkg::CMD_QUERY;
        w.point_x = 12'h000;
        w.point_y = 12'hFFF;
        add_word(w);
        for (int k = 0; k < 16; k++)
            add_cmd(cgfq_pkg::CMD_APPEND);
        add_cmd(cgfq_pkg::CMD_QUERY);
        w = '0;
        w.command = cgfq_pkg::CMD_GROW;
        add_word(w);
        add_cmd(cgfq_pkg::CMD_QUERY);
        add_cmd(cgfq_pkg::CMD_GROW);
        add_cmd(cgfq_pkg::CMD_QUERY);
        drain();

        // Random part in phases. Reset once only, so the table fills and
        // stays full; the grain centre moves between phases.
        cx[0] = 12'h000;
        cx[1] = 12'hFFF;
        cx[2] = 12'h080;
        cx[3] = 12'h7FF;
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 4)
                write_centre(cx[ph], cx[3 - ph]);
            else
                write_centre(12'($urandom), 12'($urandom));
            for (int k = 0; k < 250; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    add_cmd(cgfq_pkg::CMD_APPEND);
                    2, 3:    add_cmd(cgfq_pkg::CMD_GROW);
                    9:       add_cmd(cgfq_pkg::CMD_NOP);
                    default: add_cmd(cgfq_pkg::CMD_QUERY);
                endcase
            end
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
